// ===== hdl/brightness_contrast_pixel_map_assert.svh =====
// Assertion macros for the pixel map checker.
`ifndef BRIGHTNESS_CONTRAST_PIXEL_MAP_ASSERT_SVH
`define BRIGHTNESS_CONTRAST_PIXEL_MAP_ASSERT_SVH

// Check a property while out of reset.
`define BCPM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define BCPM_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bcpm_pkg.sv =====
`timescale 1ns / 1ps

package bcpm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int PIX_W      = 24;
    localparam int CHAN_W     = 8;
    localparam int BRIGHT_W   = 9;
    localparam int MULT_W     = 24;
    localparam int Q_W        = 16;
    localparam int KOFF_W     = 16;
    localparam int OFF_W      = 14;
    localparam int SUM_W      = 18;
    localparam int TAB_DEPTH  = 128;
    localparam int RECIP_ONE  = 1 << 23;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_RED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_GREEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_BLUE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd5;

    // Slope for zero contrast: x * 2^16 >> 16 is the identity.
    localparam logic [MULT_W-1:0] MULT_RESET = 24'h01_0000;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } bcpm_adv_t;

    typedef struct packed {
        logic [MULT_W-1:0]   mult;
        logic [KOFF_W-1:0]   koff;
        logic [BRIGHT_W-1:0] bright;
        logic                en_r;
        logic                en_g;
        logic                en_b;
        logic                fmt;
    } bcpm_cfg_t;

endpackage

// ===== hdl/bcpm_cfg.sv =====
`timescale 1ns / 1ps

module bcpm_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [bcpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bcpm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output bcpm_pkg::bcpm_cfg_t                cfg
);

    logic [bcpm_pkg::MULT_W-1:0] recip_tab [bcpm_pkg::TAB_DEPTH];
    logic [bcpm_pkg::OFF_W-1:0]  off_tab   [bcpm_pkg::TAB_DEPTH];

    // Positive contrast k: slope ceil(2^23 / (128 - k)), offset floor(128k / (128 - k)).
    for (genvar i = 0; i < bcpm_pkg::TAB_DEPTH; i++)
    begin : g_tab
        localparam int DEN = bcpm_pkg::TAB_DEPTH - i;
        localparam int RCP = (bcpm_pkg::RECIP_ONE + DEN - 1) / DEN;
        localparam int OFS = (i * bcpm_pkg::TAB_DEPTH) / DEN;
        assign recip_tab[i] = bcpm_pkg::MULT_W'(RCP);
        assign off_tab[i]   = bcpm_pkg::OFF_W'(OFS);
    end

    bcpm_pkg::bcpm_cfg_t cfg_reg;
    bcpm_pkg::bcpm_cfg_t cfg_next;
    logic [6:0]          k_idx;

    assign k_idx = cfg_data[6:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bcpm_pkg::REG_BRIGHTNESS:
                begin
                    cfg_next.bright = cfg_data;
                end
                bcpm_pkg::REG_CONTRAST:
                begin
                    if (!cfg_data[7])
                    begin
                        cfg_next.mult = recip_tab[k_idx];
                        cfg_next.koff = bcpm_pkg::KOFF_W'(-$signed({1'b0, off_tab[k_idx]}));
                    end
                    else
                    begin
                        // Negative k: slope (128 + k) * 2^9, offset -k.
                        cfg_next.mult = bcpm_pkg::MULT_W'({k_idx, 9'b0});
                        cfg_next.koff = bcpm_pkg::KOFF_W'(9'd128 - {2'b00, k_idx});
                    end
                end
                bcpm_pkg::REG_ENABLE_RED:   cfg_next.en_r = cfg_data[0];
                bcpm_pkg::REG_ENABLE_GREEN: cfg_next.en_g = cfg_data[0];
                bcpm_pkg::REG_ENABLE_BLUE:  cfg_next.en_b = cfg_data[0];
                bcpm_pkg::REG_PIXEL_FORMAT: cfg_next.fmt  = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mult   <= bcpm_pkg::MULT_RESET;
            cfg_reg.koff   <= '0;
            cfg_reg.bright <= '0;
            cfg_reg.en_r   <= 1'b1;
            cfg_reg.en_g   <= 1'b1;
            cfg_reg.en_b   <= 1'b1;
            cfg_reg.fmt    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/bcpm_chan.sv =====
`timescale 1ns / 1ps

module bcpm_chan
(
    input  logic                          clk,
    input  bcpm_pkg::bcpm_adv_t           adv,
    input  bcpm_pkg::bcpm_cfg_t           cfg,
    input  logic [bcpm_pkg::CHAN_W-1:0]   x_in,
    output logic [bcpm_pkg::CHAN_W-1:0]   y_out
);

    logic [bcpm_pkg::CHAN_W-1:0]              x_reg;
    logic [bcpm_pkg::Q_W-1:0]                 q_reg;
    logic [bcpm_pkg::Q_W-1:0]                 q_next;
    logic signed [bcpm_pkg::SUM_W-1:0]        sum_reg;
    logic signed [bcpm_pkg::SUM_W-1:0]        sum_next;
    logic [bcpm_pkg::CHAN_W+bcpm_pkg::MULT_W-1:0] prod;

    assign prod   = x_reg * cfg.mult;
    assign q_next = prod[bcpm_pkg::Q_W +: bcpm_pkg::Q_W];

    assign sum_next = $signed({2'b00, q_reg})
                    + bcpm_pkg::SUM_W'($signed(cfg.koff))
                    + bcpm_pkg::SUM_W'($signed(cfg.bright));

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            x_reg <= x_in;
        end
        if (adv.s2)
        begin
            q_reg <= q_next;
        end
        if (adv.s3)
        begin
            sum_reg <= sum_next;
        end
    end

    // Clamp to 0..255.
    always_comb
    begin
        priority if (sum_reg[bcpm_pkg::SUM_W-1])
        begin
            y_out = '0;
        end
        else if (|sum_reg[bcpm_pkg::SUM_W-2:bcpm_pkg::CHAN_W])
        begin
            y_out = '1;
        end
        else
        begin
            y_out = sum_reg[bcpm_pkg::CHAN_W-1:0];
        end
    end

endmodule

// ===== hdl/brightness_contrast_pixel_map.sv =====
`timescale 1ns / 1ps
// Channel   Signals                           Fields (low bit up)
// s_*       tvalid tready tdata[23:0] tlast   tdata: pixel_in; tlast: last_in
// m_*       tvalid tready tdata[23:0] tlast   tdata: pixel_out; tlast: last_out
// cfg_*     wr_en index[2:0] data[8:0]        register i at index i
//
// One word per cycle unless m_tready stalls, through four register stages: unpack,
// 8x24 multiply, offset add, clamp and pack. An accepted word passes all four to m_*.
// Ready ripples back from m_tready through the stage valids, so bubbles close up;
// s_tready drops only while all four stages hold words and m_tready is low.
// Reset clears the valid bits and loads register defaults.

module brightness_contrast_pixel_map
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bcpm_pkg::PIX_W-1:0]        s_tdata,   // pixel_in
    input  logic                              s_tlast,   // last_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bcpm_pkg::PIX_W-1:0]        m_tdata,   // pixel_out
    output logic                              m_tlast,   // last_out
    input  logic                              cfg_wr_en,
    input  logic [bcpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bcpm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    bcpm_pkg::bcpm_cfg_t cfg;
    bcpm_pkg::bcpm_adv_t adv;

    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic ready_out, ready3, ready2, ready1;

    logic [bcpm_pkg::PIX_W-1:0] raw1_reg, raw2_reg, raw3_reg, pix_out_reg, pix_out_next;
    logic                       last1_reg, last2_reg, last3_reg, last_out_reg;

    logic [bcpm_pkg::CHAN_W-1:0] xr, xg, xb, yr, yg, yb;

    bcpm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign ready_out = !out_valid_reg || m_tready;
    assign ready3    = !v3_reg || ready_out;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign s_tready  = ready1;

    assign adv.s1 = ready1;
    assign adv.s2 = ready2;
    assign adv.s3 = ready3;

    // Widen RGB565 fields to 8 bits, or take the three bytes of the 24-bit pixel as they are.
    assign xr = cfg.fmt ? {s_tdata[15:11], 3'b000} : s_tdata[23:16];
    assign xg = cfg.fmt ? {s_tdata[10:5], 2'b00}   : s_tdata[15:8];
    assign xb = cfg.fmt ? {s_tdata[4:0], 3'b000}   : s_tdata[7:0];

    bcpm_chan u_red   (.clk(clk), .adv(adv), .cfg(cfg), .x_in(xr), .y_out(yr));
    bcpm_chan u_green (.clk(clk), .adv(adv), .cfg(cfg), .x_in(xg), .y_out(yg));
    bcpm_chan u_blue  (.clk(clk), .adv(adv), .cfg(cfg), .x_in(xb), .y_out(yb));

    always_comb
    begin
        if (cfg.fmt)
        begin
            pix_out_next = {8'h00,
                            cfg.en_r ? yr[7:3] : raw3_reg[15:11],
                            cfg.en_g ? yg[7:2] : raw3_reg[10:5],
                            cfg.en_b ? yb[7:3] : raw3_reg[4:0]};
        end
        else
        begin
            pix_out_next = {cfg.en_r ? yr : raw3_reg[23:16],
                            cfg.en_g ? yg : raw3_reg[15:8],
                            cfg.en_b ? yb : raw3_reg[7:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= s_tvalid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready_out)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            raw1_reg  <= s_tdata;
            last1_reg <= s_tlast;
        end
        if (ready2)
        begin
            raw2_reg  <= raw1_reg;
            last2_reg <= last1_reg;
        end
        if (ready3)
        begin
            raw3_reg  <= raw2_reg;
            last3_reg <= last2_reg;
        end
        if (ready_out)
        begin
            pix_out_reg  <= pix_out_next;
            last_out_reg <= last3_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pix_out_reg;
    assign m_tlast  = last_out_reg;

endmodule

// ===== hdl/bcpm_checker.sv =====
`timescale 1ns / 1ps
`include "brightness_contrast_pixel_map_assert.svh"

module bcpm_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       s_tlast,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [bcpm_pkg::PIX_W-1:0] m_tdata,
    input logic                       m_tlast
);

    `BCPM_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")
    `BCPM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_tvalid, "output valid during reset")
    `BCPM_ASSERT(a_ready_when_empty, !s_tready |-> m_tvalid, "input stalled with empty output")
    `BCPM_ASSERT(a_latency, (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid && (m_tlast == $past(s_tlast, 4)), "word missing or frame mark lost after four cycles")

endmodule

bind brightness_contrast_pixel_map bcpm_checker u_bcpm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/pixel_map_checker.sv =====
`timescale 1ns / 1ps

module pixel_map_checker
    import bcpm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [PIX_W-1:0]        s_tdata,
    input  logic                    s_tlast,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [PIX_W-1:0]        m_tdata,
    input  logic                    m_tlast,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } pixel_word_t;

    pixel_word_t expected_words[$];

    logic signed [BRIGHT_W-1:0] brightness;
    logic signed [CHAN_W-1:0]   contrast;
    logic                       en_red;
    logic                       en_green;
    logic                       en_blue;
    logic                       rgb565;

    function automatic logic [7:0] line_map(input logic [7:0] v);
        int x;
        int k;
        int b;
        int den;
        int y;
        x = v;
        k = contrast;
        b = brightness;
        if (k >= 0)
        begin
            den = 256 - 2 * k;
            y = (x * 256) / den - (k * 256) / den + b;
        end
        else
        begin
            y = (x * (128 + k)) / 128 - k + b;
        end
        if (y < 0)
            y = 0;
        else if (y > 255)
            y = 255;
        return y[7:0];
    endfunction

    function automatic logic [PIX_W-1:0] map_pixel(input logic [PIX_W-1:0] p);
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [15:0] w;
        if (!rgb565)
        begin
            r = p[23:16];
            g = p[15:8];
            b = p[7:0];
            if (en_red)
                r = line_map(r);
            if (en_green)
                g = line_map(g);
            if (en_blue)
                b = line_map(b);
            return {r, g, b};
        end
        w = p[15:0];
        if (en_red)
        begin
            r = line_map({w[15:11], 3'b000});
            w[15:11] = r[7:3];
        end
        if (en_green)
        begin
            g = line_map({w[10:5], 2'b00});
            w[10:5] = g[7:2];
        end
        if (en_blue)
        begin
            b = line_map({w[4:0], 3'b000});
            w[4:0] = b[7:3];
        end
        return {8'h00, w};
    endfunction

    function automatic void report_field(input string field, input logic [PIX_W-1:0] want,
                                         input logic [PIX_W-1:0] got);
        fail_count++;
        $display("%0t: %s expected %06h actual %06h", $time, field, want, got);
    endfunction

    initial
    begin
        fail_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        pixel_word_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            pending    <= 0;
            brightness <= '0;
            contrast   <= '0;
            en_red     <= 1'b1;
            en_green   <= 1'b1;
            en_blue    <= 1'b1;
            rgb565     <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_words.push_back('{pixel: map_pixel(s_tdata), last: s_tlast});
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_field("unexpected word", '0, m_tdata);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tdata !== want.pixel)
                        report_field("pixel_out", want.pixel, m_tdata);
                    if (m_tlast !== want.last)
                        report_field("last_out", PIX_W'(want.last), PIX_W'(m_tlast));
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_BRIGHTNESS:   brightness <= cfg_data[BRIGHT_W-1:0];
                    REG_CONTRAST:     contrast   <= cfg_data[CHAN_W-1:0];
                    REG_ENABLE_RED:   en_red     <= cfg_data[0];
                    REG_ENABLE_GREEN: en_green   <= cfg_data[0];
                    REG_ENABLE_BLUE:  en_blue    <= cfg_data[0];
                    REG_PIXEL_FORMAT: rgb565     <= cfg_data[0];
                    default:          ;
                endcase
            end
            pending <= expected_words.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bcpm_pkg::*;

    localparam int CLK_PERIOD        = 10;
    localparam int RESET_CYCLES      = 9;
    localparam int RANDOM_SETTINGS   = 8;
    localparam int WORDS_PER_SETTING = 88;
    localparam int DRAIN_CYCLES      = 12;
    localparam int CYCLE_LIMIT       = 200000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int cycle_count  = 0;
    int fail_count;
    int pending;

    brightness_contrast_pixel_map u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pixel_map_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pixel, input logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic [8:0] bright, input logic [7:0] contr,
                                  input logic en_r, input logic en_g, input logic en_b,
                                  input logic fmt, input int phase);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BRIGHTNESS;
        cfg_data  <= bright;
        @(posedge clk);
        cfg_index <= REG_CONTRAST;
        cfg_data  <= {1'b0, contr};
        @(posedge clk);
        cfg_index <= REG_ENABLE_RED;
        cfg_data  <= CFG_DATA_W'(en_r);
        @(posedge clk);
        cfg_index <= REG_ENABLE_GREEN;
        cfg_data  <= CFG_DATA_W'(en_g);
        @(posedge clk);
        cfg_index <= REG_ENABLE_BLUE;
        cfg_data  <= CFG_DATA_W'(en_b);
        @(posedge clk);
        cfg_index <= REG_PIXEL_FORMAT;
        cfg_data  <= CFG_DATA_W'(fmt);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (phase % 4)
            0:       begin send_gap_pct <= 0;  stall_pct <= 0;  end
            1:       begin send_gap_pct <= 55; stall_pct <= 0;  end
            2:       begin send_gap_pct <= 0;  stall_pct <= 55; end
            default: begin send_gap_pct <= 36; stall_pct <= 36; end
        endcase
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [8:0] bright;
        logic [7:0] contr;
        logic       fmt;
        logic [2:0] ens;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity at reset values
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hffffff, 1'b0);
        send_pixel(24'h123456, 1'b1);

        apply_settings(9'd255, 8'd127, 1'b1, 1'b1, 1'b1, 1'b0, 0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hffffff, 1'b0);
        send_pixel(24'h7f80ff, 1'b1);

        // brightness pattern below range, flat line
        apply_settings(9'h100, 8'h80, 1'b1, 1'b1, 1'b1, 1'b0, 3);
        send_pixel(24'h00ff80, 1'b0);
        send_pixel(24'hffffff, 1'b1);

        apply_settings(9'h101, 8'hff, 1'b1, 1'b0, 1'b1, 1'b0, 2);
        send_pixel(24'h010203, 1'b0);
        send_pixel(24'hfe7f01, 1'b1);

        apply_settings(9'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1);
        send_pixel(24'hffffff, 1'b0);
        send_pixel(24'hab1234, 1'b1);

        apply_settings(9'd37, 8'h80, 1'b1, 1'b0, 1'b1, 1'b1, 0);
        send_pixel(24'h00ffff, 1'b0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hfff81f, 1'b1);

        apply_settings(-9'sd100, 8'd100, 1'b0, 1'b1, 1'b0, 1'b1, 3);
        send_pixel(24'h0007e0, 1'b0);
        send_pixel(24'h55ffff, 1'b1);

        apply_settings(9'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1, 0);
        send_pixel(24'h00ffff, 1'b0);
        send_pixel(24'hc35a5a, 1'b1);

        for (int s = 0; s < RANDOM_SETTINGS; s++)
        begin
            bright = 9'($urandom_range(511));
            contr  = 8'($urandom_range(255));
            ens    = 3'($urandom_range(7));
            fmt    = 1'($urandom_range(1));
            if (s == 0)
            begin
                bright = 9'd255;
                contr  = 8'd127;
                ens    = 3'b111;
                fmt    = 1'b0;
            end
            else if (s == 1)
            begin
                bright = 9'h100;
                contr  = 8'h80;
                ens    = 3'b111;
                fmt    = 1'b1;
            end
            else if (s == 2)
            begin
                ens = 3'b111;
            end
            apply_settings(bright, contr, ens[2], ens[1], ens[0], fmt, s);
            for (int i = 0; i < WORDS_PER_SETTING; i++)
                send_pixel(PIX_W'($urandom()), ($urandom_range(7) == 0));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bcpm_pkg.sv
hdl/bcpm_cfg.sv
hdl/bcpm_chan.sv
hdl/brightness_contrast_pixel_map.sv
hdl/bcpm_checker.sv
test/pixel_map_checker.sv
test/testbench.sv
